// File: rtl/fmrb_pkg.sv
// Types and constants shared by the framed message ring buffer modules.
package fmrb_pkg;

    localparam int RING_SIZE_W   = 13;
    localparam int MAX_PAYLOAD_W = 12;
    localparam int LEN_W         = 12;
    localparam int CMD_W         = 32;
    localparam int BYTE_W        = 8;
    localparam int MODE_W        = 2;
    localparam int STATUS_W      = 2;
    localparam int COUNT_OUT_W   = 13;
    localparam int CFG_IDX_W     = 2;
    localparam int HDR_W         = 64;

    localparam int MIN_RING  = 128;
    localparam int HDR_BYTES = 8;

    localparam logic [RING_SIZE_W-1:0]   RING_SIZE_RST   = 13'd4096;
    localparam logic [MAX_PAYLOAD_W-1:0] MAX_PAYLOAD_RST = 12'd4088;

    localparam logic [MODE_W-1:0] MODE_SEND    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PAYLOAD = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ    = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_SPACE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_SEQUENCE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_RING_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD = 2'd1;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [CMD_W-1:0]  cmd;
        logic [LEN_W-1:0]  payload_len;
        logic [BYTE_W-1:0] data_byte;
    } fmrb_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic                   is_header;
        logic [CMD_W-1:0]       cmd;
        logic [LEN_W-1:0]       len;
        logic [BYTE_W-1:0]      data_byte;
        logic                   last;
        logic [COUNT_OUT_W-1:0] free_space;
        logic [COUNT_OUT_W-1:0] stored_bytes;
    } fmrb_result_t;

endpackage

// File: rtl/fmrb_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
module fmrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/fmrb_engine.sv
// Record sequencer: pointers, counts and byte moves to and from the ring RAM.
module fmrb_engine import fmrb_pkg::*; #(
    parameter int BUF_DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     clear,
    input  logic [RING_SIZE_W-1:0]   ring_size,
    input  logic [MAX_PAYLOAD_W-1:0] max_payload,
    input  logic                     item_valid,
    output logic                     item_ready,
    input  fmrb_item_t               item,
    output logic                     res_valid,
    input  logic                     res_take,
    output fmrb_result_t             res
);

    localparam int AW = $clog2(BUF_DEPTH);
    localparam int CW = $clog2(BUF_DEPTH + 1);
    localparam int EW = (CW > RING_SIZE_W) ? CW : RING_SIZE_W;
    localparam logic [EW-1:0] DEPTH_E = EW'(BUF_DEPTH);
    localparam logic [EW-1:0] MIN_E   = EW'(MIN_RING);
    localparam logic [EW-1:0] HDR_E   = EW'(HDR_BYTES);
    localparam logic [CW-1:0] HDR_C   = CW'(HDR_BYTES);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WR_HDR,
        ST_RD_HDR,
        ST_RD_BYTE,
        ST_DONE
    } state_t;

    state_t           state_reg,     state_next;
    logic [AW-1:0]    rd_ptr_reg,    rd_ptr_next;
    logic [AW-1:0]    st_ptr_reg,    st_ptr_next;
    logic [CW-1:0]    committed_reg, committed_next;
    logic [CW-1:0]    staged_reg,    staged_next;
    logic [LEN_W-1:0] send_rem_reg,  send_rem_next;
    logic [LEN_W-1:0] read_rem_reg,  read_rem_next;
    logic             send_open_reg, send_open_next;
    logic             read_open_reg, read_open_next;
    logic [HDR_W-1:0] hdr_reg,       hdr_next;
    logic [2:0]       cnt_reg,       cnt_next;
    fmrb_result_t     res_reg,       res_next;

    logic [EW-1:0]     ring_e;
    logic [EW-1:0]     eff_e;
    logic [CW-1:0]     eff;
    logic [CW:0]       used;
    logic [CW-1:0]     free;
    logic [HDR_W-1:0]  hdr_shift;
    logic [LEN_W-1:0]  hdr_len;
    logic              ram_we;
    logic [BYTE_W-1:0] ram_wdata;
    logic              ram_re;
    logic [BYTE_W-1:0] ram_rdata;

    function automatic logic [AW-1:0] ptr_advance(input logic [AW-1:0] p,
                                                  input logic [CW-1:0] s);
        logic [CW-1:0] q;
        q = CW'(p) + CW'(1);
        return (q >= s) ? '0 : AW'(q);
    endfunction

    // Clamp the ring size into the range the RAM supports.
    always_comb begin
        ring_e = EW'(ring_size);
        if (ring_e < MIN_E) begin
            eff_e = MIN_E;
        end else if (ring_e > DEPTH_E) begin
            eff_e = DEPTH_E;
        end else begin
            eff_e = ring_e;
        end
        eff  = CW'(eff_e);
        used = (CW+1)'(committed_reg) + (CW+1)'(staged_reg);
        free = (used >= (CW+1)'(eff)) ? '0 : CW'((CW+1)'(eff) - used);
    end

    assign hdr_shift = {ram_rdata, hdr_reg[HDR_W-1:BYTE_W]};
    assign hdr_len   = hdr_shift[CMD_W +: LEN_W];

    always_comb begin
        state_next     = state_reg;
        rd_ptr_next    = rd_ptr_reg;
        st_ptr_next    = st_ptr_reg;
        committed_next = committed_reg;
        staged_next    = staged_reg;
        send_rem_next  = send_rem_reg;
        read_rem_next  = read_rem_reg;
        send_open_next = send_open_reg;
        read_open_next = read_open_reg;
        hdr_next       = hdr_reg;
        cnt_next       = cnt_reg;
        res_next       = res_reg;
        ram_we         = 1'b0;
        ram_wdata      = hdr_reg[BYTE_W-1:0];
        ram_re         = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (item_valid) begin
                    res_next   = '0;
                    state_next = ST_DONE;
                    unique case (item.mode)
                        MODE_SEND: begin
                            if (send_open_reg) begin
                                res_next.status = STATUS_SEQUENCE;
                            end else if (item.payload_len > max_payload ||
                                         EW'(free) < HDR_E + EW'(item.payload_len)) begin
                                res_next.status = STATUS_NO_SPACE;
                            end else begin
                                hdr_next      = {HDR_W'(item.payload_len) << CMD_W} |
                                                HDR_W'(item.cmd);
                                send_rem_next = item.payload_len;
                                cnt_next      = '0;
                                state_next    = ST_WR_HDR;
                            end
                        end
                        MODE_PAYLOAD: begin
                            if (!send_open_reg || send_rem_reg == '0) begin
                                res_next.status = STATUS_SEQUENCE;
                            end else begin
                                ram_we        = 1'b1;
                                ram_wdata     = item.data_byte;
                                st_ptr_next   = ptr_advance(st_ptr_reg, eff);
                                staged_next   = staged_reg + CW'(1);
                                send_rem_next = send_rem_reg - LEN_W'(1);
                                if (send_rem_reg == LEN_W'(1)) begin
                                    // final byte: make the record readable
                                    committed_next = committed_reg + staged_reg + CW'(1);
                                    staged_next    = '0;
                                    send_open_next = 1'b0;
                                    res_next.last  = 1'b1;
                                end
                            end
                        end
                        MODE_READ: begin
                            if (!read_open_reg) begin
                                if (committed_reg < HDR_C) begin
                                    res_next.status = STATUS_EMPTY;
                                end else begin
                                    ram_re         = 1'b1;
                                    rd_ptr_next    = ptr_advance(rd_ptr_reg, eff);
                                    committed_next = committed_reg - CW'(1);
                                    cnt_next       = '0;
                                    state_next     = ST_RD_HDR;
                                end
                            end else if (committed_reg == '0 || read_rem_reg == '0) begin
                                read_open_next  = 1'b0;
                                read_rem_next   = '0;
                                res_next.status = STATUS_EMPTY;
                            end else begin
                                ram_re         = 1'b1;
                                rd_ptr_next    = ptr_advance(rd_ptr_reg, eff);
                                committed_next = committed_reg - CW'(1);
                                read_rem_next  = read_rem_reg - LEN_W'(1);
                                if (read_rem_reg == LEN_W'(1)) begin
                                    read_open_next = 1'b0;
                                    res_next.last  = 1'b1;
                                end
                                state_next = ST_RD_BYTE;
                            end
                        end
                        default: begin
                            res_next.status = STATUS_SEQUENCE;
                        end
                    endcase
                end
            end
            ST_WR_HDR: begin
                // write header bytes, lowest first
                ram_we      = 1'b1;
                st_ptr_next = ptr_advance(st_ptr_reg, eff);
                staged_next = staged_reg + CW'(1);
                hdr_next    = hdr_reg >> BYTE_W;
                cnt_next    = cnt_reg + 3'd1;
                if (cnt_reg == 3'd7) begin
                    send_open_next = 1'b1;
                    if (send_rem_reg == '0) begin
                        committed_next = committed_reg + staged_reg + CW'(1);
                        staged_next    = '0;
                        send_open_next = 1'b0;
                        res_next.last  = 1'b1;
                    end
                    state_next = ST_DONE;
                end
            end
            ST_RD_HDR: begin
                // collect one byte, keep the next read in flight
                hdr_next = hdr_shift;
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg != 3'd7) begin
                    ram_re         = 1'b1;
                    rd_ptr_next    = ptr_advance(rd_ptr_reg, eff);
                    committed_next = committed_reg - CW'(1);
                end else begin
                    res_next.is_header = 1'b1;
                    res_next.cmd       = hdr_shift[CMD_W-1:0];
                    if (EW'(hdr_len) > EW'(committed_reg)) begin
                        res_next.len  = LEN_W'(committed_reg);
                        read_rem_next = LEN_W'(committed_reg);
                        res_next.last = (committed_reg == '0);
                        read_open_next = (committed_reg != '0);
                    end else begin
                        res_next.len   = hdr_len;
                        read_rem_next  = hdr_len;
                        res_next.last  = (hdr_len == '0);
                        read_open_next = (hdr_len != '0);
                    end
                    state_next = ST_DONE;
                end
            end
            ST_RD_BYTE: begin
                res_next.data_byte = ram_rdata;
                state_next         = ST_DONE;
            end
            ST_DONE: begin
                if (res_take) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // ring size write: drop everything held in the ring
        if (clear) begin
            rd_ptr_next    = '0;
            st_ptr_next    = '0;
            committed_next = '0;
            staged_next    = '0;
            send_rem_next  = '0;
            read_rem_next  = '0;
            send_open_next = 1'b0;
            read_open_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            rd_ptr_reg    <= '0;
            st_ptr_reg    <= '0;
            committed_reg <= '0;
            staged_reg    <= '0;
            send_rem_reg  <= '0;
            read_rem_reg  <= '0;
            send_open_reg <= 1'b0;
            read_open_reg <= 1'b0;
            cnt_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            rd_ptr_reg    <= rd_ptr_next;
            st_ptr_reg    <= st_ptr_next;
            committed_reg <= committed_next;
            staged_reg    <= staged_next;
            send_rem_reg  <= send_rem_next;
            read_rem_reg  <= read_rem_next;
            send_open_reg <= send_open_next;
            read_open_reg <= read_open_next;
            cnt_reg       <= cnt_next;
        end
        hdr_reg <= hdr_next;
        res_reg <= res_next;
    end

    fmrb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (BUF_DEPTH)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (st_ptr_reg),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (rd_ptr_reg),
        .rd_data (ram_rdata)
    );

    assign item_ready = (state_reg == ST_IDLE);
    assign res_valid  = (state_reg == ST_DONE);

    always_comb begin
        res              = res_reg;
        res.free_space   = COUNT_OUT_W'(free);
        res.stored_bytes = COUNT_OUT_W'(committed_reg);
    end

endmodule

// File: rtl/framed_message_ring_buffer_top.sv
// Top level of the framed message ring buffer: ports, registers, result buffer.
//
//  channel  dir  handshake           fields
//  s_       in   s_tvalid/s_tready   s_tdata, s_tuser
//  m_       out  m_tvalid/m_tready   m_tdata, m_tuser, m_tlast
//  cfg_     in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// One word at a time through the byte-wide ring RAM: a send header is written
// as 8 byte writes, a read header as 8 reads with one in flight, and a read
// payload byte or a payload write takes one RAM access; a refused word none.
// Reset needs no clearing pass; only bytes written since reset are ever read.
// A result waits in the output register while the next word is accepted;
// a stalled m_ side holds the block only once a second result is ready.
module framed_message_ring_buffer_top import fmrb_pkg::*; #(
    parameter int BUF_DEPTH = 4096
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // cmd[31:0], payload_len[43:32], data_byte[51:44], zero fill
    input  logic [55:0]            s_tdata,
    // mode[1:0]
    input  logic [MODE_W-1:0]      s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // out_cmd[31:0], out_len[43:32], out_byte[51:44], free_space[64:52],
    // stored_bytes[77:65], zero fill
    output logic [79:0]            m_tdata,
    // status[1:0], out_is_header[2]
    output logic [2:0]             m_tuser,
    output logic                   m_tlast,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [RING_SIZE_W-1:0] cfg_data
);

    logic [RING_SIZE_W-1:0]   ring_size_reg;
    logic [MAX_PAYLOAD_W-1:0] max_payload_reg;
    logic                     m_valid_reg;
    fmrb_result_t             m_res_reg;
    fmrb_item_t               item;
    fmrb_result_t             res;
    logic                     res_valid;
    logic                     out_free;
    logic                     clear;

    assign cfg_ready = 1'b1;
    assign clear     = cfg_valid && (cfg_index == REG_RING_SIZE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ring_size_reg   <= RING_SIZE_RST;
            max_payload_reg <= MAX_PAYLOAD_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_RING_SIZE:   ring_size_reg   <= cfg_data;
                REG_MAX_PAYLOAD: max_payload_reg <= cfg_data[MAX_PAYLOAD_W-1:0];
                default: ;
            endcase
        end
    end

    assign item.mode        = s_tuser;
    assign item.cmd         = s_tdata[31:0];
    assign item.payload_len = s_tdata[43:32];
    assign item.data_byte   = s_tdata[51:44];

    assign out_free = !m_valid_reg || m_tready;

    fmrb_engine #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .clear       (clear),
        .ring_size   (ring_size_reg),
        .max_payload (max_payload_reg),
        .item_valid  (s_tvalid),
        .item_ready  (s_tready),
        .item        (item),
        .res_valid   (res_valid),
        .res_take    (out_free),
        .res         (res)
    );

    // hold the result until the m_ side takes the word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= res_valid;
        end
        if (out_free && res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_res_reg.stored_bytes, m_res_reg.free_space,
                       m_res_reg.data_byte, m_res_reg.len, m_res_reg.cmd};
    assign m_tuser  = {m_res_reg.is_header, m_res_reg.status};
    assign m_tlast  = m_res_reg.last;

endmodule
